FILE: rtl/sfla_pkg.sv
// sfla_pkg: shared constants, types and a helper function for the allocator
// no dependencies
package sfla_pkg;

  localparam int Granule      = 8;
  localparam int GranBits     = 3;
  localparam int LargestClass = 128;
  localparam int ClassCount   = 16;
  localparam int ClsBits      = 4;
  localparam int RefillBlocks = 20;
  localparam int CntBits      = 5;
  localparam int AddrBits     = 16;
  localparam int LinkBits     = AddrBits - GranBits;
  localparam int LinkDepth    = 1 << LinkBits;
  localparam int WideBits     = AddrBits + 1;

  typedef enum logic [1:0] {
    StAlloc   = 2'd0,
    StFreed   = 2'd1,
    StTooBig  = 2'd2,
    StNoMem   = 2'd3
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLatch,      // capture request, compute class
    OpFreePush,   // push block_addr on its list
    OpPopRd,      // read link of class head
    OpPopWr,      // update head from link, result = old head
    OpChunkEval,  // decide pool vs heap
    OpRemPush,    // push pool remainder
    OpHeapTake,   // refill pool from heap
    OpScanStep,   // check one larger class
    OpScanRd,     // read link of scan head
    OpScanWr,     // scanned block becomes pool
    OpDivStep,    // count = left / blk, one subtract step
    OpGrant,      // carve chunk from pool
    OpLinkStep,   // write one link of the new run
    OpNoMem       // pool cleared
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic too_big;
    logic is_free;
    logic head_nz;
    logic pool_fits;
    logic need_div;
    logic div_done;
    logic left_nz;
    logic heap_ok;
    logic scan_hit;
    logic scan_end;
    logic link_done;
    logic cnt_gt1;
    logic pass_end;
  } stat_t;

  function automatic logic [ClsBits-1:0] class_of(input logic [WideBits-1:0] b);
    logic [WideBits-1:0] c;
    begin
      c = (b + WideBits'(Granule - 1)) >> GranBits;
      c = (c == '0) ? '0 : c - 1'b1;
      class_of = (c < WideBits'(ClassCount)) ? c[ClsBits-1:0] : ClsBits'(ClassCount - 1);
    end
  endfunction

endpackage

FILE: rtl/sfla_datapath.sv
// sfla_datapath: allocator state, class heads, link memory and arithmetic
// depends on sfla_pkg
module sfla_datapath import sfla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [WideBits-1:0]  cfg_wdata_i,
  input  logic                 cmd_i,
  input  logic [15:0]          size_bytes_i,
  input  logic [15:0]          block_addr_i,
  input  cmd_t                 ctl_i,
  output stat_t                stat_o,
  output logic [15:0]          result_addr_o,
  output logic [1:0]           status_o,
  output logic                 done_o
);

  logic [WideBits-1:0] limit_q;
  logic [AddrBits-1:0] heads_q [ClassCount];
  logic [AddrBits-1:0] link_mem [LinkDepth];
  logic [AddrBits-1:0] rd_q;
  logic [WideBits-1:0] pstart_q, pend_q, htop_q, htaken_q;
  logic                cmd_q;
  logic [15:0]         size_q, baddr_q;
  logic [ClsBits-1:0]  cls_q, scan_q;
  logic [WideBits-1:0] blk_q, total_q, left_q, rem_q;
  logic [CntBits-1:0]  cnt_q, k_q;
  logic [2:0]          pass_q;
  logic [AddrBits-1:0] res_q, wa_q;
  logic [1:0]          st_q;
  logic                done_q;

  logic [WideBits-1:0] left_c, get_c, lim_c, t_c;
  logic                we_c;
  logic [LinkBits-1:0] wad_c, rad_c;
  logic [AddrBits-1:0] wdt_c;

  // combinational pool and heap figures
  always_comb begin
    left_c = (pend_q >= pstart_q) ? pend_q - pstart_q : '0;
    t_c    = htaken_q >> 4;
    get_c  = (total_q << 1) + (((t_c + WideBits'(Granule - 1)) >> GranBits) << GranBits);
    lim_c  = limit_q;
  end

  // link memory write and read port selection
  always_comb begin
    we_c  = 1'b0;
    wad_c = '0;
    wdt_c = '0;
    rad_c = heads_q[cls_q][AddrBits-1:GranBits];
    unique case (ctl_i.op)
      OpFreePush: begin
        we_c = (baddr_q != '0);
        wad_c = baddr_q[AddrBits-1:GranBits];
        wdt_c = heads_q[class_of({1'b0, size_q})];
      end
      OpRemPush: begin
        we_c = 1'b1;
        wad_c = pstart_q[AddrBits-1:GranBits];
        wdt_c = heads_q[class_of(left_q)];
      end
      OpLinkStep: begin
        we_c = 1'b1;
        wad_c = wa_q[AddrBits-1:GranBits];
        wdt_c = (k_q + 1'b1 < cnt_q) ? wa_q + blk_q[AddrBits-1:0] : '0;
      end
      OpScanRd: rad_c = heads_q[scan_q][AddrBits-1:GranBits];
      default: ;
    endcase
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (we_c) link_mem[wad_c] <= wdt_c;
    rd_q <= link_mem[rad_c];
  end

  // status to controller
  always_comb begin
    stat_o.too_big   = size_q > 16'(LargestClass);
    stat_o.is_free   = cmd_q;
    stat_o.head_nz   = heads_q[cls_q] != '0;
    stat_o.pool_fits = (left_c >= total_q) || (left_c >= blk_q);
    stat_o.need_div  = left_c < total_q;
    stat_o.div_done  = rem_q < blk_q;
    stat_o.left_nz   = left_c != '0;
    stat_o.heap_ok   = (htop_q <= lim_c) && (get_c <= lim_c - htop_q);
    stat_o.scan_hit  = heads_q[scan_q] != '0;
    stat_o.scan_end  = scan_q == ClsBits'(ClassCount - 1);
    stat_o.link_done = k_q + 1'b1 >= cnt_q;
    stat_o.cnt_gt1   = cnt_q > CntBits'(1);
    stat_o.pass_end  = pass_q == 3'd3;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= WideBits'(1 << AddrBits);
      for (int i = 0; i < ClassCount; i++) heads_q[i] <= '0;
      pstart_q <= '0;
      pend_q   <= '0;
      htop_q   <= WideBits'(Granule);
      htaken_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) limit_q <= (cfg_wdata_i > WideBits'(1 << AddrBits))
                               ? WideBits'(1 << AddrBits) : cfg_wdata_i;
      unique case (ctl_i.op)
        OpLatch: begin
          cmd_q   <= cmd_i;
          size_q  <= size_bytes_i;
          baddr_q <= block_addr_i;
          cls_q   <= class_of({1'b0, size_bytes_i});
          blk_q   <= WideBits'({1'b0, class_of({1'b0, size_bytes_i})} + 1'b1) << GranBits;
          total_q <= WideBits'(({1'b0, class_of({1'b0, size_bytes_i})} + 1'b1)
                     * RefillBlocks) << GranBits;
          cnt_q   <= CntBits'(RefillBlocks);
          pass_q  <= '0;
          res_q   <= '0;
          if (size_bytes_i > 16'(LargestClass)) begin
            st_q <= StTooBig;
            done_q <= 1'b1;
          end
        end
        OpFreePush: begin
          if (baddr_q != '0) heads_q[class_of({1'b0, size_q})] <= baddr_q;
          st_q <= StFreed;
          done_q <= 1'b1;
        end
        OpPopWr: begin
          res_q <= heads_q[cls_q];
          heads_q[cls_q] <= rd_q;
          st_q <= StAlloc;
          done_q <= 1'b1;
        end
        OpChunkEval: begin
          left_q <= left_c;
          rem_q  <= left_c;
          if (stat_o.pool_fits && stat_o.need_div) cnt_q <= '0;
          scan_q <= cls_q;
        end
        OpDivStep: begin
          rem_q <= rem_q - blk_q;
          cnt_q <= cnt_q + 1'b1;
        end
        OpGrant: begin
          total_q  <= WideBits'(cnt_q) * blk_q;
          pstart_q <= pstart_q + WideBits'(cnt_q) * blk_q;
          wa_q     <= pstart_q[AddrBits-1:0] + blk_q[AddrBits-1:0];
          k_q      <= CntBits'(1);
          res_q    <= pstart_q[AddrBits-1:0];
          st_q     <= StAlloc;
          if (cnt_q > CntBits'(1)) heads_q[cls_q] <= pstart_q[AddrBits-1:0] + blk_q[AddrBits-1:0];
        end
        OpLinkStep: begin
          wa_q <= wa_q + blk_q[AddrBits-1:0];
          k_q  <= k_q + 1'b1;
        end
        // remainder goes on its list and the pool is left empty
        OpRemPush: begin
          heads_q[class_of(left_q)] <= pstart_q[AddrBits-1:0];
          pend_q <= pstart_q;
        end
        OpHeapTake: begin
          pstart_q <= htop_q;
          htop_q   <= htop_q + get_c;
          htaken_q <= htaken_q + get_c;
          pend_q   <= htop_q + get_c;
          pass_q   <= pass_q + 1'b1;
        end
        OpScanStep: if (!stat_o.scan_hit) scan_q <= scan_q + 1'b1;
        OpScanWr: begin
          pstart_q <= {1'b0, heads_q[scan_q]};
          pend_q   <= {1'b0, heads_q[scan_q]} + (WideBits'({1'b0, scan_q} + 1'b1) << GranBits);
          heads_q[scan_q] <= rd_q;
          pass_q   <= pass_q + 1'b1;
        end
        OpNoMem: begin
          pstart_q <= '0;
          pend_q   <= '0;
          res_q    <= '0;
          st_q     <= StNoMem;
          done_q   <= 1'b1;
        end
        default: ;
      endcase
      if (ctl_i.op == OpGrant && cnt_q <= CntBits'(1)) done_q <= 1'b1;
      if (ctl_i.op == OpLinkStep && stat_o.link_done) done_q <= 1'b1;
    end
  end

  assign result_addr_o = res_q;
  assign status_o      = st_q;
  assign done_o        = done_q;

endmodule

FILE: rtl/sfla_ctrl.sv
// sfla_ctrl: request sequencer for the allocator
// depends on sfla_pkg
module sfla_ctrl import sfla_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  input  logic  done_i,
  output cmd_t  ctl_o,
  output logic  busy_o
);

  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001,
    SDisp  = 11'b00000000010,
    SPopRd = 11'b00000000100,
    SPopWr = 11'b00000001000,
    SEval  = 11'b00000010000,
    SDiv   = 11'b00000100000,
    SGrant = 11'b00001000000,
    SLink  = 11'b00010000000,
    SMiss  = 11'b00100000000,
    SScan  = 11'b01000000000,
    SWait  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   scan_rd_q, scan_rd_d;

  always_comb begin
    state_d   = state_q;
    scan_rd_d = 1'b0;
    ctl_o.op  = OpNone;
    unique case (state_q)
      SIdle: if (start_i) begin
        ctl_o.op = OpLatch;
        state_d = SDisp;
      end
      SDisp: begin
        if (stat_i.too_big) state_d = SWait;
        else if (stat_i.is_free) begin
          ctl_o.op = OpFreePush;
          state_d = SWait;
        end else if (stat_i.head_nz) state_d = SPopRd;
        else state_d = SEval;
      end
      SPopRd: begin
        ctl_o.op = OpPopRd;
        state_d = SPopWr;
      end
      SPopWr: begin
        ctl_o.op = OpPopWr;
        state_d = SWait;
      end
      SEval: begin
        ctl_o.op = OpChunkEval;
        if (stat_i.pass_end && !stat_i.pool_fits) begin
          ctl_o.op = OpNoMem;
          state_d = SWait;
        end else if (stat_i.pool_fits) state_d = stat_i.need_div ? SDiv : SGrant;
        else state_d = SMiss;
      end
      SDiv: if (stat_i.div_done) state_d = SGrant;
            else ctl_o.op = OpDivStep;
      SGrant: begin
        ctl_o.op = OpGrant;
        state_d = stat_i.cnt_gt1 ? SLink : SWait;
      end
      SLink: begin
        ctl_o.op = OpLinkStep;
        if (stat_i.link_done) state_d = SWait;
      end
      SMiss: begin
        if (stat_i.left_nz) ctl_o.op = OpRemPush;
        else if (stat_i.heap_ok) begin
          ctl_o.op = OpHeapTake;
          state_d = SEval;
        end else state_d = SScan;
      end
      SScan: begin
        if (scan_rd_q) begin
          ctl_o.op = OpScanWr;
          state_d = SEval;
        end else if (stat_i.scan_hit) begin
          ctl_o.op = OpScanRd;
          scan_rd_d = 1'b1;
        end else if (stat_i.scan_end) begin
          ctl_o.op = OpNoMem;
          state_d = SWait;
        end else ctl_o.op = OpScanStep;
      end
      SWait: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      scan_rd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_rd_q <= scan_rd_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  // a result word is only reported after a request was taken
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> busy_o) else $error("done without request");
  a_start_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request not taken");
  a_wait_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWait) |=> !busy_o) else $error("wait did not return idle");

endmodule

FILE: rtl/segregated_free_list_allocator.sv
// segregated_free_list_allocator: top level, controller plus datapath
// depends on sfla_pkg, sfla_ctrl, sfla_datapath
//
// Usage: raise start with cmd_i, size_bytes_i and block_addr_i while busy
// is low; the word is taken at that edge. One result word follows, shown for
// a single cycle with valid_o high on result_addr_o and status_o. The
// receiver cannot stall; results are not held. A free or a size too large
// ends at dispatch; a class-list hit reads the link, then pops. A grant
// links the further blocks of its run (up to 19), after dividing the pool
// remainder by the block size when short of a full run. On a miss any
// remainder is pushed on its list, then the pool refills from the heap, else
// from a larger class found by an upward scan. A full refill grants 20
// blocks. Only one request is in flight. heap_limit is written via
// cfg_we_i/cfg_wdata_i while idle; the user is bound to this, the block
// does not enforce it. Reset empties all class lists, the pool and the
// heap; the link memory is not cleared and needs no sweep.
module segregated_free_list_allocator import sfla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [15:0] size_bytes_i,
  input  logic [15:0] block_addr_i,
  output logic        valid_o,
  output logic [15:0] result_addr_o,
  output logic [1:0]  status_o
);

  cmd_t  ctl;
  stat_t stat;
  logic  done;

  sfla_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .stat_i(stat), .done_i(done),
    .ctl_o(ctl), .busy_o(busy)
  );

  sfla_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .cmd_i, .size_bytes_i,
    .block_addr_i, .ctl_i(ctl), .stat_o(stat), .result_addr_o,
    .status_o, .done_o(done)
  );

  assign valid_o = done;

endmodule

FILE: sim/tb.sv
// tb: self-checking bench for segregated_free_list_allocator
// depends on sfla_pkg and the allocator rtl; predicts every result word itself
`timescale 1ns / 1ps

module tb;
  import sfla_pkg::*;

  typedef struct {
    bit [15:0]          addr;
    sfla_pkg::status_e  status;
  } word_t;

  typedef struct {
    bit [15:0] addr;
    bit [15:0] size;
  } live_t;

  // free-list allocator predictor plus queue of expected result words
  class alloc_scoreboard;
    bit [16:0] heap_limit;
    bit [15:0] list_heads [16];
    bit [15:0] link_mem [8192];
    bit [16:0] pool_start;
    bit [16:0] pool_end;
    bit [16:0] heap_top;
    bit [16:0] heap_taken;
    int unsigned grant_cnt;
    word_t expected_words[$];
    int errors;

    function new();
      heap_limit = 17'd65536;
      foreach (list_heads[i]) list_heads[i] = '0;
      pool_start = '0;
      pool_end = '0;
      heap_top = 17'd8;
      heap_taken = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void set_limit(bit [16:0] v);
      heap_limit = v;
    endfunction

    function int unsigned size_class(longint unsigned bytes);
      longint unsigned c;
      c = (bytes + 7) / 8;
      c = (c == 0) ? 0 : c - 1;
      return (c < 16) ? int'(c) : 15;
    endfunction

    function void push_free(int unsigned cls, longint unsigned addr);
      bit [15:0] a;
      a = addr[15:0];
      link_mem[a[15:3]] = list_heads[cls];
      list_heads[cls] = a;
    endfunction

    function bit [15:0] pop_free(int unsigned cls);
      bit [15:0] a;
      a = list_heads[cls];
      list_heads[cls] = link_mem[a[15:3]];
      return a;
    endfunction

    // carve a run from the pool, refilling it from the heap or a larger class
    function longint unsigned carve_run(int unsigned cls, longint unsigned blk);
      longint unsigned total, left, t, get, lim, r;
      bit found;
      for (int pass = 0; pass < 4; pass++) begin
        total = blk * grant_cnt;
        left = (pool_end >= pool_start) ? pool_end - pool_start : 0;
        if (left >= total || left >= blk) begin
          if (left < total) begin
            grant_cnt = int'(left / blk);
            total = blk * grant_cnt;
          end
          r = pool_start;
          pool_start = pool_start + total;
          return r;
        end
        t = heap_taken >> 4;
        get = 2 * total + ((t + 7) / 8) * 8;
        if (left > 0) push_free(size_class(left), pool_start);
        lim = (heap_limit < 17'd65536) ? heap_limit : 65536;
        if (heap_top <= lim && get <= lim - heap_top) begin
          pool_start = heap_top;
          heap_top = heap_top + get;
          heap_taken = heap_taken + get;
          pool_end = pool_start + get;
        end else begin
          found = 0;
          for (int i = cls; i < 16; i++) begin
            if (!found && list_heads[i] != 0) begin
              pool_start = pop_free(i);
              pool_end = pool_start + (i + 1) * 8;
              found = 1;
            end
          end
          if (!found) begin
            pool_start = '0;
            pool_end = '0;
            return 0;
          end
        end
      end
      return 0;
    endfunction

    // predict the word for one accepted request and queue it
    function word_t note_request(bit cmd, bit [15:0] size, bit [15:0] addr);
      word_t w;
      int unsigned cls;
      longint unsigned blk, chunk;
      w.addr = '0;
      cls = size_class(size);
      if (size > 128) begin
        w.status = sfla_pkg::StTooBig;
      end else if (cmd) begin
        if (addr != 0) push_free(cls, addr);
        w.status = sfla_pkg::StFreed;
      end else if (list_heads[cls] != 0) begin
        w.addr = pop_free(cls);
        w.status = sfla_pkg::StAlloc;
      end else begin
        blk = (cls + 1) * 8;
        grant_cnt = 20;
        chunk = carve_run(cls, blk);
        if (chunk == 0) begin
          w.status = sfla_pkg::StNoMem;
        end else begin
          w.addr = chunk[15:0];
          w.status = sfla_pkg::StAlloc;
          if (grant_cnt > 1) begin
            list_heads[cls] = 16'(chunk + blk);
            for (int k = 1; k < grant_cnt; k++)
              link_mem[16'(chunk + k * blk) >> 3] =
                (k + 1 < grant_cnt) ? 16'(chunk + (k + 1) * blk) : 16'd0;
          end
        end
      end
      expected_words.push_back(w);
      return w;
    endfunction

    function void check_word(bit [15:0] addr, bit [1:0] status);
      word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected word: result_addr %0d status %0d", addr, status);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (addr != w.addr) begin
        $error("result_addr: expected %0d actual %0d", w.addr, addr);
        errors++;
      end
      if (status != w.status) begin
        $error("status: expected %0d actual %0d", w.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [16:0] cfg_wdata_i = '0;
  logic        start = 0;
  logic        busy;
  logic        cmd_i = 0;
  logic [15:0] size_bytes_i = '0;
  logic [15:0] block_addr_i = '0;
  logic        valid_o;
  logic [15:0] result_addr_o;
  logic [1:0]  status_o;

  alloc_scoreboard sb = new();
  live_t live_blocks[$];
  int unsigned cycles = 0;
  int item_no = 0;

  segregated_free_list_allocator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .start(start), .busy(busy),
    .cmd_i(cmd_i), .size_bytes_i(size_bytes_i), .block_addr_i(block_addr_i),
    .valid_o(valid_o), .result_addr_o(result_addr_o), .status_o(status_o)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_word(result_addr_o, status_o);
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // send one request word, optionally idling first; start stays high after
  task automatic send_word(bit cmd, bit [15:0] size, bit [15:0] addr);
    word_t w;
    live_t lb;
    bit quiet;
    quiet = (item_no > 500 && item_no < 850);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1;
    cmd_i <= cmd;
    size_bytes_i <= size;
    block_addr_i <= addr;
    do @(posedge clk_i); while (busy);
    w = sb.note_request(cmd, size, addr);
    if (!cmd && w.status == StAlloc) begin
      lb.addr = w.addr;
      lb.size = size;
      live_blocks.push_back(lb);
    end
    item_no++;
  endtask

  // wait for idle, then write heap_limit
  task automatic write_limit(bit [16:0] v);
    start <= 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_limit(v);
  endtask

  task automatic random_word();
    int unsigned r, idx;
    live_t lb;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_word(0, 16'($urandom_range(0, 128)), 16'($urandom));
    end else if (r < 62) begin
      send_word(0, 16'($urandom_range(0, 24)), 16'($urandom));
    end else if (r < 88 && live_blocks.size() > 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      lb = live_blocks[idx];
      live_blocks.delete(idx);
      send_word(1, lb.size, lb.addr);
    end else if (r < 93) begin
      send_word(1, 16'($urandom_range(0, 128)), 16'($urandom));
    end else if (r < 96) begin
      send_word(1'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      send_word(1, 16'($urandom_range(0, 128)), 16'd0);
    end
  endtask

  initial begin
    bit [16:0] limits [5];
    limits = '{17'd2000, 17'd8, 17'd65536, 17'd700, 17'd131071};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: size extremes, both commands, null and misaligned frees
    send_word(0, 16'd0, 16'hFFFF);
    send_word(0, 16'd1, 16'd0);
    send_word(0, 16'd8, 16'd0);
    send_word(0, 16'd9, 16'd0);
    send_word(0, 16'd128, 16'd0);
    send_word(0, 16'd129, 16'd0);
    send_word(0, 16'hFFFF, 16'hFFFF);
    send_word(1, 16'hFFFF, 16'd64);
    send_word(1, 16'd16, 16'd0);
    send_word(1, 16'd0, 16'd13);
    send_word(1, 16'd128, 16'hFFF8);
    send_word(0, 16'd128, 16'd0);
    send_word(0, 16'd128, 16'd0);
    send_word(0, 16'd1, 16'd0);
    send_word(1, 16'd120, 16'h5555);
    send_word(1, 16'd7, 16'hAAAA);
    send_word(0, 16'd100, 16'd0);
    send_word(0, 16'd64, 16'd0);

    // heap limit above the address space
    write_limit(17'd131071);
    repeat (250) random_word();
    foreach (limits[i]) begin
      write_limit(limits[i]);
      repeat (250) random_word();
    end
    write_limit(17'($urandom_range(8, 65536)));
    repeat (50) random_word();

    start <= 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: segregated_free_list_allocator.f
rtl/sfla_pkg.sv
rtl/sfla_datapath.sv
rtl/sfla_ctrl.sv
rtl/segregated_free_list_allocator.sv
sim/tb.sv
